### sv/hrlp_pkg.sv
package hrlp_pkg;

  // Request limits
  localparam int MAX_REQUEST_BYTES = 65536;
  localparam int METHOD_WORD_BYTES = 7;

  localparam int MW_W  = 8 * METHOD_WORD_BYTES;
  localparam int POS_W = $clog2(MAX_REQUEST_BYTES) + 1;
  localparam int OFF_W = 17;
  localparam int LEN_W = 4;
  localparam logic [LEN_W-1:0] LEN_CAP = 4'd15;

  // Result queue
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = FQ_AW + 1;

  // Special bytes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    KIND_METHOD     = 3'd0,
    KIND_PATH_BYTE  = 3'd1,
    KIND_PATH_DONE  = 3'd2,
    KIND_HEADER_END = 3'd3,
    KIND_EARLY_END  = 3'd4
  } kind_t;

  typedef logic [3:0] method_t;

  localparam int      NUM_METHODS    = 9;
  localparam method_t METHOD_UNKNOWN = 4'd9;

  // Method names, first character in the low byte
  localparam logic [63:0] METHOD_TEXT [NUM_METHODS] = '{
    64'h0000_0000_0054_4547,  // GET
    64'h0000_0000_4441_4548,  // HEAD
    64'h0000_0000_5453_4F50,  // POST
    64'h0000_0000_0054_5550,  // PUT
    64'h0000_4554_454C_4544,  // DELETE
    64'h0054_4345_4E4E_4F43,  // CONNECT
    64'h0053_4E4F_4954_504F,  // OPTIONS
    64'h0000_0045_4341_5254,  // TRACE
    64'h0000_0048_4354_4150   // PATCH
  };

  localparam logic [LEN_W-1:0] METHOD_LEN [NUM_METHODS] = '{
    4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5, 4'd5
  };

  typedef struct packed {
    kind_t            kind;
    method_t          method;
    logic [7:0]       path_byte;
    logic             seg_start;
    logic [OFF_W-1:0] offset;
    logic             last;
  } res_t;

  function automatic method_t match_method(logic [MW_W-1:0] word, logic [LEN_W-1:0] len);
    method_t code;
    logic    hit;
    code = METHOD_UNKNOWN;
    hit  = 1'b0;
    for (int m = 0; m < NUM_METHODS; m++) begin
      if (!hit && len == METHOD_LEN[m] && int'(METHOD_LEN[m]) <= METHOD_WORD_BYTES &&
          METHOD_TEXT[m][MW_W-1:0] == word) begin
        code = method_t'(m);
        hit  = 1'b1;
      end
    end
    return code;
  endfunction

endpackage

### sv/hrlp_in_if.sv
interface hrlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

### sv/hrlp_out_if.sv
interface hrlp_out_if import hrlp_pkg::*;;
  logic             valid;
  logic             ready;
  kind_t            result_kind;
  method_t          method_code;
  logic [7:0]       path_byte;
  logic             segment_start;
  logic [OFF_W-1:0] body_offset;
  logic             last_in_run;

  modport source (output valid, output result_kind, output method_code, output path_byte,
                  output segment_start, output body_offset, output last_in_run,
                  input ready);
  modport sink   (input valid, input result_kind, input method_code, input path_byte,
                  input segment_start, input body_offset, input last_in_run,
                  output ready);
endinterface

### sv/http_request_line_parser.sv
// HTTP request line parser.
// in_ch carries one request byte per transfer, with first_byte marking the
// start of a request and last_byte the final byte available. out_ch carries
// result items: method decided, path bytes split into segments, path complete,
// header end, and early end of data. A byte gives zero, one or two results;
// the last one of a byte has last_in_run set.
// Each result is registered in the result queue before out_ch offers it.
// Throughput: one byte per cycle while the receiver keeps up; a byte that
// gives two results takes two queue entries and two output transfers. The parse logic is
// one pass of compare and flag logic per byte, and the four-entry result
// queue is the only buffer, so in_ch.ready drops once three results wait.
// Reset (rst_n low, synchronous) starts a fresh request and empties the
// result queue. When the receiver stalls, the queue fills and in_ch.ready
// goes low; no result is lost or reordered. Once a request has ended, bytes
// give no results until a byte with first_byte set.
module http_request_line_parser import hrlp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  hrlp_in_if.sink      in_ch,
  hrlp_out_if.source   out_ch
);

  // Parse state
  logic [MW_W-1:0]  method_word_r, word_nxt, cur_word;
  logic [LEN_W-1:0] word_len_r, len_nxt, cur_len;
  logic [1:0]       word_idx_r, idx_nxt, cur_idx;
  logic             nl_seen_r, nl_nxt, cur_nl;
  logic             after_slash_r, after_nxt, cur_after;
  logic [POS_W-1:0] byte_pos_r, pos_nxt, cur_pos;
  method_t          method_r, method_nxt, cur_method;
  logic             done_r, done_nxt, cur_done;

  // Result queue
  res_t             fq_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FQ_CW-1:0] cnt_r;

  logic             in_fire, out_fire;
  logic [7:0]       b;
  logic [POS_W:0]   pos_inc, pos_inc2;
  logic             a_v, b_v;
  res_t             res_a, res_b, push_first;
  logic [1:0]       push_n;
  res_t             head;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign b        = in_ch.data_byte;

  always_comb begin
    // A first byte starts from the reset state
    cur_word   = in_ch.first_byte ? '0 : method_word_r;
    cur_len    = in_ch.first_byte ? '0 : word_len_r;
    cur_idx    = in_ch.first_byte ? '0 : word_idx_r;
    cur_nl     = in_ch.first_byte ? 1'b0 : nl_seen_r;
    cur_after  = in_ch.first_byte ? 1'b1 : after_slash_r;
    cur_pos    = in_ch.first_byte ? '0 : byte_pos_r;
    cur_method = in_ch.first_byte ? METHOD_UNKNOWN : method_r;
    cur_done   = in_ch.first_byte ? 1'b0 : done_r;

    word_nxt   = cur_word;
    len_nxt    = cur_len;
    idx_nxt    = cur_idx;
    nl_nxt     = cur_nl;
    after_nxt  = cur_after;
    pos_nxt    = cur_pos;
    method_nxt = cur_method;
    done_nxt   = cur_done;

    pos_inc  = {1'b0, cur_pos} + (POS_W+1)'(1);
    pos_inc2 = {1'b0, cur_pos} + (POS_W+1)'(2);

    a_v   = 1'b0;
    b_v   = 1'b0;
    res_a = '0;
    res_b = '0;

    if (!cur_done) begin
      if (b == CH_NUL) begin
        a_v          = 1'b1;
        res_a.kind   = KIND_EARLY_END;
        res_a.offset = OFF_W'(pos_inc);
        done_nxt     = 1'b1;
      end else if (b == CH_SPACE) begin
        // Close a nonempty word; empty words are skipped
        if (cur_len != '0) begin
          if (cur_idx == 2'd0) begin
            method_nxt = match_method(cur_word, cur_len);
            a_v        = 1'b1;
            res_a.kind = KIND_METHOD;
          end else if (cur_idx == 2'd1) begin
            a_v        = 1'b1;
            res_a.kind = KIND_PATH_DONE;
          end
          len_nxt  = '0;
          word_nxt = '0;
          if (cur_idx < 2'd2) begin
            idx_nxt = cur_idx + 2'd1;
          end
        end
      end else if (b == CH_LF) begin
        if (cur_nl) begin
          a_v          = 1'b1;
          res_a.kind   = KIND_HEADER_END;
          res_a.offset = OFF_W'(pos_inc);
          done_nxt     = 1'b1;
        end else begin
          nl_nxt = 1'b1;
        end
      end else if (b != CH_CR) begin
        nl_nxt = 1'b0;
        if (cur_idx == 2'd0) begin
          // Collect the method word, dropping bytes past its capacity
          for (int k = 0; k < METHOD_WORD_BYTES; k++) begin
            if (cur_len == LEN_W'(k)) begin
              word_nxt[8*k +: 8] = b;
            end
          end
        end else if (cur_idx == 2'd1) begin
          if (b == CH_SLASH) begin
            after_nxt = 1'b1;
          end else begin
            a_v             = 1'b1;
            res_a.kind      = KIND_PATH_BYTE;
            res_a.path_byte = b;
            res_a.seg_start = cur_after;
            after_nxt       = 1'b0;
          end
        end
        if (cur_len < LEN_CAP) begin
          len_nxt = cur_len + LEN_W'(1);
        end
      end

      // Advance the position; end on the last available byte or the size limit
      if (!done_nxt) begin
        pos_nxt = POS_W'(pos_inc);
        if (in_ch.last_byte || pos_inc >= (POS_W+1)'(MAX_REQUEST_BYTES)) begin
          b_v          = 1'b1;
          res_b.kind   = KIND_EARLY_END;
          res_b.offset = OFF_W'(pos_inc2);
          done_nxt     = 1'b1;
        end
      end
    end

    res_a.method = method_nxt;
    res_b.method = method_nxt;
    res_a.last   = 1'b0;
    res_b.last   = 1'b1;

    push_first      = a_v ? res_a : res_b;
    push_first.last = !(a_v && b_v);
    push_n          = in_fire ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_word_r <= '0;
      word_len_r    <= '0;
      word_idx_r    <= '0;
      nl_seen_r     <= 1'b0;
      after_slash_r <= 1'b1;
      byte_pos_r    <= '0;
      method_r      <= METHOD_UNKNOWN;
      done_r        <= 1'b0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      cnt_r         <= '0;
    end else begin
      if (in_fire) begin
        method_word_r <= word_nxt;
        word_len_r    <= len_nxt;
        word_idx_r    <= idx_nxt;
        nl_seen_r     <= nl_nxt;
        after_slash_r <= after_nxt;
        byte_pos_r    <= pos_nxt;
        method_r      <= method_nxt;
        done_r        <= done_nxt;
      end
      wr_ptr_r <= wr_ptr_r + FQ_AW'(push_n);
      rd_ptr_r <= rd_ptr_r + FQ_AW'(out_fire);
      cnt_r    <= cnt_r + FQ_CW'(push_n) - FQ_CW'(out_fire);
    end
  end

  // Queue payload: hold one or two results of the accepted byte
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fq_r[wr_ptr_r] <= push_first;
    end
    if (push_n == 2'd2) begin
      fq_r[wr_ptr_r + FQ_AW'(1)] <= res_b;
    end
  end

  assign head = fq_r[rd_ptr_r];

  assign in_ch.ready          = cnt_r < FQ_CW'(FQ_DEPTH - 1);
  assign out_ch.valid         = cnt_r != '0;
  assign out_ch.result_kind   = head.kind;
  assign out_ch.method_code   = head.method;
  assign out_ch.path_byte     = head.path_byte;
  assign out_ch.segment_start = head.seg_start;
  assign out_ch.body_offset   = head.offset;
  assign out_ch.last_in_run   = head.last;

endmodule

### sv/hrlp_checker.sv
module hrlp_checker import hrlp_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       out_kind,
  input logic [7:0]       out_path_byte,
  input logic             out_seg,
  input logic [OFF_W-1:0] out_off,
  input logic             out_last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_path_byte) && $stable(out_off) && $stable(out_last))
    else $error("stalled result changed");

  a_path_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_PATH_BYTE |->
      out_path_byte != CH_NUL && out_path_byte != CH_SPACE && out_path_byte != CH_SLASH &&
      out_path_byte != CH_LF && out_path_byte != CH_CR)
    else $error("path byte carries a separator");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_HEADER_END || out_kind == KIND_EARLY_END) |->
      out_last && out_off != '0)
    else $error("request end not final or without offset");

  a_other_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_HEADER_END && out_kind != KIND_EARLY_END |->
      out_off == '0 && (out_kind == KIND_PATH_BYTE || (out_path_byte == '0 && !out_seg)))
    else $error("unused result fields not zero");

endmodule

bind http_request_line_parser hrlp_checker u_hrlp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kind      (out_ch.result_kind),
  .out_path_byte (out_ch.path_byte),
  .out_seg       (out_ch.segment_start),
  .out_off       (out_ch.body_offset),
  .out_last      (out_ch.last_in_run)
);
